// File: sv/fsk_pkg.sv
// shared types, codes and defaults for the fsk tape byte modulator
`timescale 1ns / 1ps

package fsk_pkg;

    // default tone timing and queue sizing
    localparam int SLOW_HALF_FRAMES_DEF = 4;
    localparam int FAST_HALF_FRAMES_DEF = 2;
    localparam int QUEUE_DEPTH_DEF      = 2;

    // operation codes of an input beat
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_SLOW = 2'd2;
    localparam logic [1:0] OP_FAST = 2'd3;

    // job kinds held by the back end
    localparam logic [1:0] JOB_IDLE = 2'd0;
    localparam logic [1:0] JOB_BYTE = 2'd1;
    localparam logic [1:0] JOB_SLOW = 2'd2;
    localparam logic [1:0] JOB_FAST = 2'd3;

    // bit positions of a framed byte
    localparam logic [3:0] START_POS = 4'd0;
    localparam logic [3:0] STOP_POS  = 4'd9;
    localparam int         FRAME_BITS = 10;

    // configuration register indexes
    localparam int          CFG_IDX_W = 3;
    localparam logic [2:0]  CFG_LOW_LEVEL  = 3'd0;
    localparam logic [2:0]  CFG_HIGH_LEVEL = 3'd1;
    localparam logic [2:0]  CFG_ZERO_FAST  = 3'd2;
    localparam logic [2:0]  CFG_ZERO_SLOW  = 3'd3;
    localparam logic [2:0]  CFG_ONE_FAST   = 3'd4;
    localparam logic [2:0]  CFG_ONE_SLOW   = 3'd5;

    // configuration reset values
    localparam logic [7:0] LOW_LEVEL_RST  = 8'd64;
    localparam logic [7:0] HIGH_LEVEL_RST = 8'd192;
    localparam logic [7:0] ZERO_FAST_RST  = 8'd8;
    localparam logic [7:0] ZERO_SLOW_RST  = 8'd2;
    localparam logic [7:0] ONE_FAST_RST   = 8'd4;
    localparam logic [7:0] ONE_SLOW_RST   = 8'd4;

    // classified command from the front end
    typedef struct packed {
        logic [1:0]  op;
        logic        tone_empty;
        logic [7:0]  data_byte;
        logic [15:0] tone_cycles;
    } fsk_cmd_t;

    // front to back: head of the command queue
    typedef struct packed {
        logic     avail;
        fsk_cmd_t cmd;
    } fsk_head_t;

    // one result beat
    typedef struct packed {
        logic [7:0] sample_level;
        logic       sample_valid;
        logic       accepted;
        logic       last_sample;
    } fsk_result_t;

endpackage

// File: sv/fsk_tape_byte_modulator_top.sv
// top level of the fsk tape byte modulator
//
//  channel   direction  handshake            payload
//  input     in         push / full          operation, data_byte, tone_cycles
//  result    out        empty / pop          sample_level, sample_valid, accepted, last_sample
//  config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  one beat in, one result beat out; sustained rate one beat per clock while the consumer keeps popping
//  a pushed beat is registered in the command queue, then in the result queue, before it reaches the ports
//  the job state update in the back end takes one step per beat and sets the rate
//  reset is asynchronous; no clearing pass, the block takes beats right after reset
//  a stalled consumer fills the result queue, then the command queue, then raises full
`timescale 1ns / 1ps

module fsk_tape_byte_modulator_top
    import fsk_pkg::*;
#(
    parameter int SLOW_HALF_FRAMES = SLOW_HALF_FRAMES_DEF,
    parameter int FAST_HALF_FRAMES = FAST_HALF_FRAMES_DEF,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           operation,
    input  logic [7:0]           data_byte,
    input  logic [15:0]          tone_cycles,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           sample_level,
    output logic                 sample_valid,
    output logic                 accepted,
    output logic                 last_sample,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    fsk_head_t   head;
    logic        head_pop;
    fsk_result_t result;

    // accept and classify
    fsk_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .data_byte   (data_byte),
        .tone_cycles (tone_cycles),
        .head        (head),
        .head_pop    (head_pop)
    );

    // run the jobs
    fsk_back #(
        .SLOW_HALF_FRAMES (SLOW_HALF_FRAMES),
        .FAST_HALF_FRAMES (FAST_HALF_FRAMES),
        .QUEUE_DEPTH      (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .head_pop  (head_pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    assign sample_level = result.sample_level;
    assign sample_valid = result.sample_valid;
    assign accepted     = result.accepted;
    assign last_sample  = result.last_sample;

endmodule

// File: sv/fsk_fifo.sv
// small register fifo used between the stages and at the result side
`timescale 1ns / 1ps

module fsk_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/fsk_front.sv
// front end: takes input beats, classifies them and queues them
`timescale 1ns / 1ps

module fsk_front
    import fsk_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic [7:0]  data_byte,
    input  logic [15:0] tone_cycles,
    output fsk_head_t   head,
    input  logic        head_pop
);

    fsk_cmd_t cmd_in;
    fsk_cmd_t cmd_out;
    logic     q_empty;

    // classify the incoming beat
    always_comb
    begin
        cmd_in.op          = operation;
        cmd_in.tone_empty  = (tone_cycles == 16'd0);
        cmd_in.data_byte   = data_byte;
        cmd_in.tone_cycles = tone_cycles;
    end

    // command queue toward the back end
    fsk_fifo #(
        .WIDTH ($bits(fsk_cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (head_pop),
        .rd_data (cmd_out),
        .empty   (q_empty)
    );

    assign head.avail = !q_empty;
    assign head.cmd   = cmd_out;

endmodule

// File: sv/fsk_back.sv
// back end: modulator job state, configuration and result queue
`timescale 1ns / 1ps

module fsk_back
    import fsk_pkg::*;
#(
    parameter int SLOW_HALF_FRAMES = SLOW_HALF_FRAMES_DEF,
    parameter int FAST_HALF_FRAMES = FAST_HALF_FRAMES_DEF,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fsk_head_t            head,
    output logic                 head_pop,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 empty,
    input  logic                 pop,
    output fsk_result_t          result
);

    localparam logic [4:0] SLOW_FRAMES = 5'(SLOW_HALF_FRAMES);
    localparam logic [4:0] FAST_FRAMES = 5'(FAST_HALF_FRAMES);

    typedef struct packed {
        logic       found;
        logic [3:0] pos;
        logic [7:0] fast;
        logic [7:0] slow;
    } fsk_seek_t;

    // configuration registers
    logic [7:0] low_level_reg, high_level_reg;
    logic [7:0] zero_fast_reg, zero_slow_reg, one_fast_reg, one_slow_reg;

    // job state
    logic [1:0]  job_reg, job_next;
    logic [7:0]  shift_reg, shift_next;
    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  fast_left_reg, fast_left_next;
    logic [7:0]  slow_left_reg, slow_left_next;
    logic [15:0] tone_left_reg, tone_left_next;
    logic [3:0]  fih_reg, fih_next;
    logic        half_high_reg, half_high_next;

    fsk_result_t res;
    fsk_seek_t   seek_cmd, seek_adv;
    logic        res_full;
    logic        fire;
    logic        is_fast;
    logic [4:0]  frames;
    logic [3:0]  fih_inc;
    logic [7:0]  fast_dec, slow_dec;
    logic [15:0] tone_dec;

    // first bit at or after a position whose cycle counts are not both zero
    function automatic fsk_seek_t seek(
        input logic [7:0] sd,
        input logic [3:0] from,
        input logic [7:0] zf,
        input logic [7:0] zs,
        input logic [7:0] of,
        input logic [7:0] os
    );
        fsk_seek_t r;
        logic      b;
        logic [7:0] f;
        logic [7:0] s;
        r = '0;
        for (int p = 0; p < FRAME_BITS; p++)
        begin
            if (4'(p) == START_POS)
                b = 1'b0;
            else if (4'(p) == STOP_POS)
                b = 1'b1;
            else
                b = sd[3'(p - 1)];
            f = b ? of : zf;
            s = b ? os : zs;
            if (!r.found && (4'(p) >= from) && ((f != 8'd0) || (s != 8'd0)))
            begin
                r.found = 1'b1;
                r.pos   = 4'(p);
                r.fast  = f;
                r.slow  = s;
            end
        end
        return r;
    endfunction

    assign fire      = head.avail && !res_full;
    assign head_pop  = fire;
    assign cfg_ready = 1'b1;

    // next bit search, for a new byte and for the running byte
    always_comb
    begin
        seek_cmd = seek(head.cmd.data_byte, START_POS, zero_fast_reg, zero_slow_reg,
                        one_fast_reg, one_slow_reg);
        seek_adv = seek(shift_reg, pos_reg + 4'd1, zero_fast_reg, zero_slow_reg,
                        one_fast_reg, one_slow_reg);
    end

    // tone timing helpers
    always_comb
    begin
        is_fast  = (job_reg == JOB_BYTE) ? (fast_left_reg != 8'd0) : (job_reg == JOB_FAST);
        frames   = is_fast ? FAST_FRAMES : SLOW_FRAMES;
        fih_inc  = fih_reg + 4'd1;
        fast_dec = fast_left_reg;
        slow_dec = slow_left_reg;
        if (fast_left_reg != 8'd0)
            fast_dec = fast_left_reg - 8'd1;
        else if (slow_left_reg != 8'd0)
            slow_dec = slow_left_reg - 8'd1;
        tone_dec = (tone_left_reg != 16'd0) ? tone_left_reg - 16'd1 : tone_left_reg;
    end

    // job step for the command at the head of the queue
    always_comb
    begin
        job_next       = job_reg;
        shift_next     = shift_reg;
        pos_next       = pos_reg;
        fast_left_next = fast_left_reg;
        slow_left_next = slow_left_reg;
        tone_left_next = tone_left_reg;
        fih_next       = fih_reg;
        half_high_next = half_high_reg;
        res            = '0;
        unique case (head.cmd.op)
            OP_TICK:
            begin
                if (job_reg != JOB_IDLE)
                begin
                    res.sample_level = half_high_reg ? high_level_reg : low_level_reg;
                    res.sample_valid = 1'b1;
                    if ((fih_inc == 4'd0) || ({1'b0, fih_inc} >= frames))
                    begin
                        fih_next = 4'd0;
                        if (!half_high_reg)
                        begin
                            half_high_next = 1'b1;
                        end
                        else
                        begin
                            // end of a full cycle
                            half_high_next = 1'b0;
                            if (job_reg == JOB_BYTE)
                            begin
                                fast_left_next = fast_dec;
                                slow_left_next = slow_dec;
                                if ((fast_dec == 8'd0) && (slow_dec == 8'd0))
                                begin
                                    if (seek_adv.found)
                                    begin
                                        pos_next       = seek_adv.pos;
                                        fast_left_next = seek_adv.fast;
                                        slow_left_next = seek_adv.slow;
                                    end
                                    else
                                    begin
                                        pos_next = STOP_POS;
                                        job_next = JOB_IDLE;
                                    end
                                end
                            end
                            else
                            begin
                                tone_left_next = tone_dec;
                                if (tone_dec == 16'd0)
                                    job_next = JOB_IDLE;
                            end
                        end
                    end
                    else
                    begin
                        fih_next = fih_inc;
                    end
                    res.last_sample = (job_next == JOB_IDLE);
                end
            end
            OP_BYTE:
            begin
                if (job_reg == JOB_IDLE)
                begin
                    res.accepted   = 1'b1;
                    fih_next       = 4'd0;
                    half_high_next = 1'b0;
                    shift_next     = head.cmd.data_byte;
                    if (seek_cmd.found)
                    begin
                        job_next       = JOB_BYTE;
                        pos_next       = seek_cmd.pos;
                        fast_left_next = seek_cmd.fast;
                        slow_left_next = seek_cmd.slow;
                    end
                    else
                    begin
                        pos_next       = STOP_POS;
                        fast_left_next = 8'd0;
                        slow_left_next = 8'd0;
                    end
                end
            end
            OP_SLOW, OP_FAST:
            begin
                if (job_reg == JOB_IDLE)
                begin
                    res.accepted   = 1'b1;
                    fih_next       = 4'd0;
                    half_high_next = 1'b0;
                    tone_left_next = head.cmd.tone_cycles;
                    if (!head.cmd.tone_empty)
                        job_next = (head.cmd.op == OP_SLOW) ? JOB_SLOW : JOB_FAST;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    // job state registers, advanced once per beat taken from the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg       <= JOB_IDLE;
            shift_reg     <= 8'd0;
            pos_reg       <= START_POS;
            fast_left_reg <= 8'd0;
            slow_left_reg <= 8'd0;
            tone_left_reg <= 16'd0;
            fih_reg       <= 4'd0;
            half_high_reg <= 1'b0;
        end
        else if (fire)
        begin
            job_reg       <= job_next;
            shift_reg     <= shift_next;
            pos_reg       <= pos_next;
            fast_left_reg <= fast_left_next;
            slow_left_reg <= slow_left_next;
            tone_left_reg <= tone_left_next;
            fih_reg       <= fih_next;
            half_high_reg <= half_high_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_level_reg  <= LOW_LEVEL_RST;
            high_level_reg <= HIGH_LEVEL_RST;
            zero_fast_reg  <= ZERO_FAST_RST;
            zero_slow_reg  <= ZERO_SLOW_RST;
            one_fast_reg   <= ONE_FAST_RST;
            one_slow_reg   <= ONE_SLOW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LOW_LEVEL:  low_level_reg  <= cfg_data;
                CFG_HIGH_LEVEL: high_level_reg <= cfg_data;
                CFG_ZERO_FAST:  zero_fast_reg  <= cfg_data;
                CFG_ZERO_SLOW:  zero_slow_reg  <= cfg_data;
                CFG_ONE_FAST:   one_fast_reg   <= cfg_data;
                CFG_ONE_SLOW:   one_slow_reg   <= cfg_data;
                default:        low_level_reg  <= low_level_reg;
            endcase
        end
    end

    // result queue toward the consumer
    fsk_fifo #(
        .WIDTH ($bits(fsk_result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fire),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

// File: sv/fsk_checker.sv
// port level checks for the fsk tape byte modulator, bound to the top level
`timescale 1ns / 1ps

module fsk_checker
    import fsk_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] sample_level,
    input logic       sample_valid,
    input logic       accepted,
    input logic       last_sample
);

    // a beat is never both a taken command and a sample
    a_acc_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(accepted && sample_valid))
        else $error("result beat is both accepted command and sample");

    // the final sample flag only rides on a real sample
    a_last_is_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_sample) |-> sample_valid)
        else $error("last_sample without sample_valid");

    // beats without a sample carry a zero level
    a_idle_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !sample_valid) |-> (sample_level == 8'd0))
        else $error("nonzero level on a beat without a sample");

    // a waiting result holds while the consumer stalls
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(sample_level) && $stable(sample_valid)
                              && $stable(accepted) && $stable(last_sample)))
        else $error("result beat changed while stalled");

endmodule

bind fsk_tape_byte_modulator_top fsk_checker u_fsk_checker (.*);
